/* rtl/core/pmpc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor package
// Shared widths, constants and types for the mouse packet decoder.
// ----------------------------------------------------------------------------
package pmpc_pkg;

	localparam int POS_W       = 12;
	localparam int SCREEN_W    = 12;
	localparam int CURSOR_SIZE = 16;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_ADDR_W  = 1;

	localparam logic [7:0] ACK_BYTE   = 8'hFA;
	localparam logic [7:0] SYNC_MASK  = 8'hC8;
	localparam logic [7:0] SYNC_VALUE = 8'h08;

	localparam logic [POS_W-1:0] CURSOR_COL_RST = POS_W'(152);
	localparam logic [POS_W-1:0] CURSOR_ROW_RST = POS_W'(78);
	localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = SCREEN_W'(320);
	localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = SCREEN_W'(200);

	localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] head;
		logic [7:0] x_byte;
		logic [7:0] y_byte;
	} packet_t;

endpackage
`default_nettype wire

/* rtl/core/ps2_mouse_packet_cursor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor
// Frames raw PS/2 mouse bytes into three-byte packets and tracks a cursor.
// ----------------------------------------------------------------------------
// The block takes one mouse byte per clock cycle, stalling only on a third
// byte while the two-entry packet queue is full. Bytes are ignored until the
// acknowledge byte 0xFA arrives; after that, bytes are framed into packets and
// a first byte that fails the sync check is dropped. Each complete packet gives
// one result word with the buttons, the sign-extended deltas (Y negated, so
// down is positive) and the cursor position after the move, clamped to
// 0 .. screen size - 16. The queue joins the framer and the cursor unit; a
// packet enters it on its third byte and its result is registered when popped.
// Screen sizes are written through the configuration port at index 0 (width)
// and 1 (height), by the user only while idle; the block does not enforce it.
module ps2_mouse_packet_cursor (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pmpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [pmpc_pkg::SCREEN_W-1:0]    cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [pmpc_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] mouse_byte
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [2:0] buttons, [11:3] delta_x, [21:12] delta_y, [33:22] cursor_x,
	// [45:34] cursor_y, [47:46] zero
	output logic [pmpc_pkg::OUT_TDATA_W-1:0]      m_tdata
);
	import pmpc_pkg::*;

	logic    push;
	packet_t push_pkt;
	logic    queue_full;
	logic    queue_not_empty;
	logic    pop;
	packet_t pop_pkt;

	pmpc_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push       (push),
		.push_pkt   (push_pkt),
		.queue_full (queue_full)
	);

	pmpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pkt  (push_pkt),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.pop       (pop),
		.pop_pkt   (pop_pkt)
	);

	pmpc_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.pkt_valid (queue_not_empty),
		.pkt       (pop_pkt),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

/* rtl/core/pmpc_framer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet framer
// Waits for the acknowledge byte, then frames three-byte packets and pushes
// each complete packet into the packet queue.
// ----------------------------------------------------------------------------
module pmpc_framer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [pmpc_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] mouse_byte
	output logic                                  push,
	output pmpc_pkg::packet_t                     push_pkt,
	input  wire logic                             queue_full
);
	import pmpc_pkg::*;

	typedef enum logic [2:0] {
		ST_ACK   = 3'b001,
		ST_BYTE1 = 3'b010,
		ST_BYTE2 = 3'b100
	} phase_t;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] head_q;
	logic [7:0] x_byte_q;
	logic       awaiting_ack_q;
	logic       accept;
	logic       sync_ok;

	assign s_tready = awaiting_ack_q || (phase_q != ST_BYTE2) || !queue_full;
	assign accept   = s_tvalid && s_tready;
	assign sync_ok  = (s_tdata & SYNC_MASK) == SYNC_VALUE;

	assign push          = accept && !awaiting_ack_q && (phase_q == ST_BYTE2);
	assign push_pkt.head   = head_q;
	assign push_pkt.x_byte = x_byte_q;
	assign push_pkt.y_byte = s_tdata;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			ST_ACK:   phase_d = sync_ok ? ST_BYTE1 : ST_ACK;
			ST_BYTE1: phase_d = ST_BYTE2;
			ST_BYTE2: phase_d = ST_ACK;
			default:  phase_d = ST_ACK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= ST_ACK;
			awaiting_ack_q <= 1'b1;
		end else if (accept) begin
			if (awaiting_ack_q) begin
				if (s_tdata == ACK_BYTE) begin
					awaiting_ack_q <= 1'b0;
				end
				phase_q <= ST_ACK;
			end else begin
				phase_q <= phase_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !awaiting_ack_q) begin
			if (phase_q == ST_ACK && sync_ok) begin
				head_q <= s_tdata;
			end
			if (phase_q == ST_BYTE1) begin
				x_byte_q <= s_tdata;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/pmpc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet queue
// Two-entry queue of framed packets between the framer and the cursor unit.
// ----------------------------------------------------------------------------
module pmpc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire pmpc_pkg::packet_t push_pkt,
	output logic                   full,
	output logic                   not_empty,
	input  wire logic              pop,
	output pmpc_pkg::packet_t      pop_pkt
);
	import pmpc_pkg::*;

	packet_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign pop_pkt   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_pkt;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/pmpc_cursor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse cursor unit
// Holds the screen size registers, decodes packets into buttons and deltas,
// moves the clamped cursor and drives the registered result stream.
// ----------------------------------------------------------------------------
module pmpc_cursor (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pmpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [pmpc_pkg::SCREEN_W-1:0]    cfg_data,
	input  wire logic                             pkt_valid,
	input  wire pmpc_pkg::packet_t                pkt,
	output logic                                  pop,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [pmpc_pkg::OUT_TDATA_W-1:0]      m_tdata
);
	import pmpc_pkg::*;

	function automatic logic [POS_W-1:0] move_clamped(
		input logic [POS_W-1:0]    pos,
		input logic signed [9:0]   delta,
		input logic [SCREEN_W-1:0] screen
	);
		logic signed [POS_W+1:0] sum;
		logic [POS_W-1:0]        bound;
		sum = $signed({2'b00, pos}) + $signed({{(POS_W-8){delta[9]}}, delta});
		bound = (screen >= SCREEN_W'(CURSOR_SIZE)) ? POS_W'(screen - SCREEN_W'(CURSOR_SIZE))
			: '0;
		if (sum[POS_W+1]) begin
			move_clamped = '0;
		end else if (sum[POS_W:0] > {1'b0, bound}) begin
			move_clamped = bound;
		end else begin
			move_clamped = sum[POS_W-1:0];
		end
	endfunction

	logic [SCREEN_W-1:0] screen_width_q;
	logic [SCREEN_W-1:0] screen_height_q;
	logic [POS_W-1:0]    cursor_col_q;
	logic [POS_W-1:0]    cursor_row_q;
	logic                out_valid_q;
	logic [2:0]          buttons_q;
	logic [8:0]          delta_x_q;
	logic [9:0]          delta_y_q;
	logic [8:0]          dx;
	logic [9:0]          dy_raw;
	logic [9:0]          dy;
	logic [POS_W-1:0]    col_next;
	logic [POS_W-1:0]    row_next;

	assign dx       = {pkt.head[4], pkt.x_byte};
	assign dy_raw   = {pkt.head[5], pkt.head[5], pkt.y_byte};
	assign dy       = 10'd0 - dy_raw;
	assign col_next = move_clamped(cursor_col_q, {dx[8], dx}, screen_width_q);
	assign row_next = move_clamped(cursor_row_q, dy, screen_height_q);

	assign pop      = pkt_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, 12'(cursor_row_q), 12'(cursor_col_q), delta_y_q, delta_x_q,
		buttons_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= CURSOR_COL_RST;
			cursor_row_q <= CURSOR_ROW_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				cursor_col_q <= col_next;
				cursor_row_q <= row_next;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			buttons_q <= pkt.head[2:0];
			delta_x_q <= dx;
			delta_y_q <= dy;
		end
	end

endmodule
`default_nettype wire
